FILE: rtl/brlfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the run-length frame decoder.
// Depends on nothing; imported by every module of the block.
package brlfd_pkg;

    localparam int MAX_RESULTS = 62;
    localparam int CNT_W       = 6;
    localparam int POS_W       = 5;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_FIELD = 2'd1;
    localparam logic [1:0] PH_FCOL  = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             colour;
        logic             fend;
    } t_blk;

    typedef struct packed {
        logic gen;
        logic flush;
    } t_out_ctl;

    typedef struct packed {
        logic step;
        logic clear;
    } t_pos_ctl;

endpackage

FILE: rtl/brlfd_pos.sv
`timescale 1ns / 1ps
// Grid position unit: column and row counters with the shared end-of-frame compare.
// Depends on brlfd_pkg.
module brlfd_pos
    import brlfd_pkg::*;
#(
    parameter int COLS = 30,
    parameter int ROWS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pos_ctl         i_ctl,
    output logic [POS_W-1:0] o_col,
    output logic [POS_W-1:0] o_row,
    output logic             o_fend
);

    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          col_end;

    assign col_end = (r_col == COL_LAST);
    assign o_fend  = col_end && (r_row == ROW_LAST);
    assign o_col   = POS_W'(r_col);
    assign o_row   = POS_W'(r_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_ctl.step) begin
            if (o_fend) begin
                r_col <= '0;
                r_row <= '0;
            end else if (col_end) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/brlfd_out.sv
`timescale 1ns / 1ps
// Result hold stage and output register; marks the final result of each byte.
// Depends on brlfd_pkg.
module brlfd_out
    import brlfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_out_ctl    i_ctl,
    input  t_blk        i_res,
    output logic        o_stall,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // block_col[4:0], block_row[9:5], block_colour[10], zeros
    output logic [0:0]  m_axis_tuser,  // frame_end[0]
    output logic        m_axis_tlast
);

    t_blk r_pend;
    logic r_pvalid;
    t_blk r_res;
    logic r_last;
    logic r_ovalid;
    logic out_free;
    logic load_out;

    assign out_free = !r_ovalid || m_axis_tready;
    assign load_out = (i_ctl.gen || i_ctl.flush) && r_pvalid;
    assign o_stall  = load_out && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (!o_stall) begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_ctl.gen) begin
                r_pvalid <= 1'b1;
            end else if (i_ctl.flush) begin
                r_pvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            if (load_out) begin
                r_res  <= r_pend;
                r_last <= !i_ctl.gen;
            end
            if (i_ctl.gen) begin
                r_pend <= i_res;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_res.colour, r_res.row, r_res.col};
    assign m_axis_tuser  = r_res.fend;
    assign m_axis_tlast  = r_last;

endmodule

FILE: rtl/bitstream_run_length_frame_decoder.sv
`timescale 1ns / 1ps
// Run-length frame decoder, top level: bit sequencer over one byte at a time.
// A byte holds the decoder through each stream bit, each block stepped, each run entry not
// stopped by a frame end and the flush, plus any output stalls.
// Ready only between bytes; a result waits in the hold stage for the next block or the flush,
// so every result passes through the hold stage before it reaches the output register.
// Synchronous active-low reset returns every decoder field but the byte register to its start state.
module bitstream_run_length_frame_decoder
    import brlfd_pkg::*;
#(
    parameter int COLS     = 30,
    parameter int ROWS     = 20,
    parameter int RUN_BITS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // stream_byte[7:0]
    input  logic        s_axis_tlast,  // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // block_col[4:0], block_row[9:5], block_colour[10], zeros
    output logic [0:0]  m_axis_tuser,  // frame_end[0]
    output logic        m_axis_tlast   // last
);

    localparam int HW = (RUN_BITS > 1) ? $clog2(RUN_BITS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BIT   = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [2:0]          r_idx, n_idx;
    logic [7:0]          r_byte, n_byte;
    logic                r_eos, n_eos;
    logic [1:0]          r_phase, n_phase;
    logic                r_colour, n_colour;
    logic [RUN_BITS-1:0] r_field, n_field;
    logic [HW-1:0]       r_held, n_held;
    logic [RUN_BITS-1:0] r_run, n_run;
    logic                r_ended, n_ended;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    logic                adv;
    logic                bit_in;
    logic                keep;
    logic                field_done;
    logic                stall;
    logic [POS_W-1:0]    pos_col;
    logic [POS_W-1:0]    pos_row;
    logic                pos_fend;
    t_pos_ctl            pos_ctl;
    t_out_ctl            out_ctl;
    t_blk                res;

    brlfd_pos #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pos_ctl),
        .o_col   (pos_col),
        .o_row   (pos_row),
        .o_fend  (pos_fend)
    );

    assign res = '{col: pos_col, row: pos_row, colour: r_colour, fend: pos_fend};

    brlfd_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (out_ctl),
        .i_res         (res),
        .o_stall       (stall),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign bit_in        = r_byte[r_idx];
    assign keep          = (r_cnt < CNT_W'(MAX_RESULTS));
    assign field_done    = (({1'b0, r_held} + 1'b1) >= (HW+1)'(RUN_BITS));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_byte   = r_byte;
        n_eos    = r_eos;
        n_phase  = r_phase;
        n_colour = r_colour;
        n_field  = r_field;
        n_held   = r_held;
        n_run    = r_run;
        n_ended  = r_ended;
        n_cnt    = r_cnt;
        adv      = 1'b0;
        pos_ctl  = '0;
        out_ctl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_byte  = s_axis_tdata;
                    n_eos   = s_axis_tlast;
                    n_idx   = 3'd7;
                    n_cnt   = '0;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                unique case (r_phase)
                    PH_START: begin
                        n_colour = bit_in;
                        n_ended  = 1'b1;
                        n_phase  = PH_FIELD;
                        adv      = 1'b1;
                    end
                    PH_FCOL: begin
                        n_colour = bit_in;
                        n_phase  = PH_FIELD;
                        n_state  = S_RUN;
                    end
                    default: begin
                        n_field = RUN_BITS'({r_field, bit_in});
                        if (field_done) begin
                            n_run   = RUN_BITS'({r_field, bit_in});
                            n_field = '0;
                            n_held  = '0;
                            n_state = S_RUN;
                        end else begin
                            n_held = r_held + 1'b1;
                            adv    = 1'b1;
                        end
                    end
                endcase
            end
            S_RUN: begin
                if (r_run != '0) begin
                    out_ctl.gen = keep;
                    if (!(keep && stall)) begin
                        if (keep) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        n_run        = r_run - 1'b1;
                        pos_ctl.step = 1'b1;
                        if (pos_fend) begin
                            n_ended = 1'b1;
                            n_phase = PH_FCOL;
                            adv     = 1'b1;
                        end else begin
                            n_ended = 1'b0;
                        end
                    end
                end else begin
                    if (!r_ended) begin
                        n_colour = !r_colour;
                    end
                    adv = 1'b1;
                end
            end
            S_FLUSH: begin
                out_ctl.flush = 1'b1;
                if (!stall) begin
                    n_state = S_IDLE;
                    if (r_eos) begin
                        n_phase       = PH_START;
                        n_colour      = 1'b0;
                        n_field       = '0;
                        n_held        = '0;
                        n_run         = '0;
                        n_ended       = 1'b1;
                        pos_ctl.clear = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (adv) begin
            if (r_idx == 3'd0) begin
                n_state = S_FLUSH;
            end else begin
                n_idx   = r_idx - 1'b1;
                n_state = S_BIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_START;
            r_colour <= 1'b0;
            r_field  <= '0;
            r_held   <= '0;
            r_run    <= '0;
            r_ended  <= 1'b1;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_eos    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_colour <= n_colour;
            r_field  <= n_field;
            r_held   <= n_held;
            r_run    <= n_run;
            r_ended  <= n_ended;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_eos    <= n_eos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

FILE: test/bitstream_run_length_frame_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the run-length frame decoder: streams bytes in, predicts blocks.
// Depends on brlfd_pkg and bitstream_run_length_frame_decoder, and through it on brlfd_pos and brlfd_out.
module bitstream_run_length_frame_decoder_tb;
    import brlfd_pkg::*;

    localparam int COLS         = 30;
    localparam int ROWS         = 20;
    localparam int RUN_BITS     = 5;
    localparam int FRAME_BLOCKS = COLS * ROWS;
    localparam int TAIL_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [7:0] data;
        logic       eos;
        logic       drain;
        int         idle_pct;
        int         stall_pct;
    } t_stream_req;

    typedef struct packed {
        t_blk blk;
        logic last;
    } t_block_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // stream_byte[7:0]
    logic        s_axis_tlast = 1'b0;   // end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // block_col[4:0], block_row[9:5], block_colour[10], zeros
    logic [0:0]  m_axis_tuser;          // frame_end[0]
    logic        m_axis_tlast;          // last

    t_stream_req pending_bytes[$];
    t_block_exp  expected_blocks[$];
    t_block_exp  byte_blocks[$];
    int          cur_idle_pct;
    int          cur_stall_pct;
    int          rx_stall_pct;
    int          fault_cnt;
    int          cycle_cnt;
    bit          byte_taken;

    // decoder state as predicted
    logic [RUN_BITS-1:0] rl_field;
    logic [2:0]          rl_nbits;
    logic [1:0]          rl_phase;
    logic                rl_colour;
    logic [4:0]          rl_col;
    logic [4:0]          rl_row;
    logic [RUN_BITS-1:0] rl_left;
    logic                rl_ended;

    bitstream_run_length_frame_decoder #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .RUN_BITS (RUN_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_decoder();
        rl_field  = '0;
        rl_nbits  = '0;
        rl_phase  = PH_START;
        rl_colour = 1'b0;
        rl_col    = '0;
        rl_row    = '0;
        rl_left   = '0;
        rl_ended  = 1'b1;
    endtask

    task automatic put_block(input logic fend);
        t_block_exp e;
        if (byte_blocks.size() < MAX_RESULTS) begin
            e.blk.col    = rl_col;
            e.blk.row    = rl_row;
            e.blk.colour = rl_colour;
            e.blk.fend   = fend;
            e.last       = 1'b0;
            byte_blocks.push_back(e);
        end
    endtask

    // emit pending blocks; stop at a frame end to await its colour bit
    task automatic expand_run();
        logic fend;
        while (rl_left != 0) begin
            fend = (rl_col + 1 >= COLS) && (rl_row + 1 >= ROWS);
            put_block(fend);
            rl_left--;
            if (fend) begin
                rl_col   = '0;
                rl_row   = '0;
                rl_ended = 1'b1;
                rl_phase = PH_FCOL;
                return;
            end
            rl_ended = 1'b0;
            rl_col++;
            if (rl_col >= COLS) begin
                rl_col = '0;
                rl_row++;
            end
        end
        if (!rl_ended)
            rl_colour = ~rl_colour;
    endtask

    task automatic take_bit(input logic b);
        case (rl_phase)
            PH_START: begin
                rl_colour = b;
                rl_ended  = 1'b1;
                rl_phase  = PH_FIELD;
            end
            PH_FCOL: begin
                rl_colour = b;
                rl_phase  = PH_FIELD;
                expand_run();
            end
            default: begin
                rl_field = {rl_field[RUN_BITS-2:0], b};
                rl_nbits++;
                if (rl_nbits >= RUN_BITS) begin
                    rl_left  = rl_field;
                    rl_field = '0;
                    rl_nbits = '0;
                    expand_run();
                end
            end
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] data, input logic eos);
        t_block_exp e;
        byte_blocks.delete();
        for (int i = 7; i >= 0; i--)
            take_bit(data[i]);
        if (byte_blocks.size() != 0) begin
            e = byte_blocks.pop_back();
            e.last = 1'b1;
            byte_blocks.push_back(e);
        end
        foreach (byte_blocks[i])
            expected_blocks.push_back(byte_blocks[i]);
        if (eos)
            clear_decoder();
    endtask

    task automatic add_byte(input logic [7:0] data, input logic eos, input logic drain);
        t_stream_req r;
        r.data      = data;
        r.eos       = eos;
        r.drain     = drain;
        r.idle_pct  = cur_idle_pct;
        r.stall_pct = cur_stall_pct;
        pending_bytes.push_back(r);
    endtask

    // well-formed stream: start colour, run fields, a colour bit after each frame end
    task automatic add_stream(input int nbytes);
        bit         bits[$];
        int         pos;
        int         run;
        logic [7:0] b;
        pos = 0;
        bits.push_back(1'($urandom_range(1)));
        while (bits.size() < 8 * nbytes) begin
            case ($urandom_range(7))
                0:          run = 0;
                1, 2, 3, 4: run = 31;
                default:    run = $urandom_range(30, 1);
            endcase
            for (int k = RUN_BITS - 1; k >= 0; k--)
                bits.push_back(run[k]);
            if (run != 0 && pos + run >= FRAME_BLOCKS) begin
                bits.push_back(1'($urandom_range(1)));
                pos = pos + run - FRAME_BLOCKS;
            end else begin
                pos = pos + run;
            end
        end
        for (int i = 0; i < nbytes; i++) begin
            for (int k = 0; k < 8; k++)
                b[7-k] = bits[8*i+k];
            add_byte(b, i == nbytes - 1, 1'b0);
        end
    endtask

    // drive requests and receiver stalls on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || byte_taken) begin
                byte_taken = 1'b0;
                if (pending_bytes.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bytes[0].drain && expected_blocks.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if ($urandom_range(99) < pending_bytes[0].idle_pct) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    rx_stall_pct = pending_bytes[0].stall_pct;
                    s_axis_tdata  <= pending_bytes[0].data;
                    s_axis_tlast  <= pending_bytes[0].eos;
                    s_axis_tvalid <= 1'b1;
                    pending_bytes.pop_front();
                end
            end
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // check results, then predict for accepted requests
    always @(posedge i_clk) begin
        t_block_exp e;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** bitstream_run_length_frame_decoder: FAILED **");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_blocks.size() == 0) begin
                $error("unexpected block: col %0d row %0d", m_axis_tdata[4:0],
                       m_axis_tdata[9:5]);
                fault_cnt++;
            end else begin
                e = expected_blocks.pop_front();
                if (m_axis_tdata[4:0] !== e.blk.col) begin
                    $error("block_col: expected %0d, got %0d", e.blk.col, m_axis_tdata[4:0]);
                    fault_cnt++;
                end
                if (m_axis_tdata[9:5] !== e.blk.row) begin
                    $error("block_row: expected %0d, got %0d", e.blk.row, m_axis_tdata[9:5]);
                    fault_cnt++;
                end
                if (m_axis_tdata[10] !== e.blk.colour) begin
                    $error("block_colour: expected %0d, got %0d", e.blk.colour,
                           m_axis_tdata[10]);
                    fault_cnt++;
                end
                if (m_axis_tuser[0] !== e.blk.fend) begin
                    $error("frame_end: expected %0d, got %0d", e.blk.fend, m_axis_tuser[0]);
                    fault_cnt++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
                    fault_cnt++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            byte_taken = 1'b1;
            decode_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    initial begin
        int idle_set[4];
        int stall_set[4];
        idle_set  = '{0, 47, 0, 17};
        stall_set = '{0, 0, 47, 17};
        fault_cnt     = 0;
        cycle_cnt     = 0;
        byte_taken    = 1'b0;
        rx_stall_pct  = 0;
        cur_idle_pct  = 0;
        cur_stall_pct = 0;
        clear_decoder();

        // short runs, zero runs, end of stream mid-field and after a start colour
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h80, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'h7F, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h55, 1'b0, 1'b0);
        add_byte(8'hAA, 1'b1, 1'b0);
        // full-length runs across a frame end, colour bit read mid-run
        for (int i = 0; i < 14; i++)
            add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);

        for (int p = 0; p < 4; p++) begin
            cur_idle_pct  = idle_set[p];
            cur_stall_pct = stall_set[p];
            add_stream($urandom_range(24, 12));
            for (int i = 0; i < 5; i++)
                add_byte(8'($urandom), ($urandom_range(7) == 0) || i == 4, p == 2 && i == 0);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_blocks.size() != 0) begin
            $error("blocks never delivered: %0d", expected_blocks.size());
            fault_cnt++;
        end
        if (fault_cnt == 0)
            $display("** bitstream_run_length_frame_decoder: PASSED **");
        else
            $display("** bitstream_run_length_frame_decoder: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/brlfd_pkg.sv
rtl/brlfd_pos.sv
rtl/brlfd_out.sv
rtl/bitstream_run_length_frame_decoder.sv
test/bitstream_run_length_frame_decoder_tb.sv
